@@ rtl/grid_maze_depth_first_walker_macros.svh @@
// ----------------------------------------------------------------------------
// Grid maze walker assertion macros
// Shorthands for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef GRID_MAZE_DEPTH_FIRST_WALKER_MACROS_SVH
`define GRID_MAZE_DEPTH_FIRST_WALKER_MACROS_SVH

// same-cycle implication
`define GMDFW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GMDFW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gmdfw_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid maze walker package
// Event, direction, mark and phase codes of the walker; the checker shares the event and direction codes.
// ----------------------------------------------------------------------------
package gmdfw_pkg;

  localparam int COORD_W = 7;
  localparam int EXT_W   = 9;   // coordinate plus one, and sizes up to 256
  localparam int CFG_W   = 8;
  localparam int IDX_W   = 2;

  localparam logic [2:0] EV_START   = 3'd0;
  localparam logic [2:0] EV_MOVE    = 3'd1;
  localparam logic [2:0] EV_BACK    = 3'd2;
  localparam logic [2:0] EV_EXIT    = 3'd3;
  localparam logic [2:0] EV_NO_EXIT = 3'd4;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic [1:0] MARK_WALL = 2'd0;
  localparam logic [1:0] MARK_OPEN = 2'd1;
  localparam logic [1:0] MARK_SEEN = 2'd2;

  localparam logic [IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [IDX_W-1:0] REG_NUM_COLS = 2'd1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEARCH,
    PH_DONE
  } phase_t;

endpackage

@@ rtl/gmdfw_ram.sv @@
// ----------------------------------------------------------------------------
// Grid maze walker RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module gmdfw_ram #(
  parameter int DW    = 2,
  parameter int AW    = 14,
  parameter int DEPTH = 16384
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/grid_maze_depth_first_walker.sv @@
// ----------------------------------------------------------------------------
// Grid maze depth-first walker
// Loads a maze cell by cell, then steps a depth-first search one event per tick.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write num_rows (index 0) or num_cols (index 1) while idle.
//   in_*   : in_mode 0 loads one cell (no result), 1 is a step tick that
//            yields at most one event word on out_*.
//   out_*  : one event word per tick until the search finishes.
// Steps:
//   A load, the first tick after loading or a tick after the end is handled
//   in the idle state alone. A search tick does one stack read, then a mark
//   read and check for each candidate neighbor (no read when off the grid),
//   then pushes the new frame on a move; a back-up is done in the probe state.
//   Each memory has one read port, so neighbors are probed one at a time.
//   The event word of a start tick is registered on acceptance and shows in
//   the next cycle; a search tick registers it as the tick ends, and a move
//   word appears while its push is still being done.
// Reset: control state clears, sizes go to 1x1, start to 0,0. Maze marks and
//   stack are not cleared; every cell in range must be loaded first.
// Stall: a held event word stays in the output register; a new item is
//   taken only once that register is free or being drained.
// ----------------------------------------------------------------------------
module grid_maze_depth_first_walker
  import gmdfw_pkg::*;
#(
  parameter int MAX_DIM = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [COORD_W-1:0] in_load_row,
  input  logic [COORD_W-1:0] in_load_col,
  input  logic               in_cell_open,
  input  logic               in_is_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_event_res,
  output logic [1:0]         out_direction,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic [COORD_W-1:0] out_from_row,
  output logic [COORD_W-1:0] out_from_col,
  output logic               out_finished
);

  localparam int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MADDR_W = 2 * AW;
  localparam int GRID    = MAX_DIM * MAX_DIM;
  localparam int SADDR_W = $clog2(GRID);
  localparam int DEPTH_W = $clog2(GRID + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_PROBE,
    S_EVAL,
    S_PUSH
  } state_t;

  function automatic logic [MADDR_W-1:0] cell_addr(input logic [EXT_W-1:0] r,
                                                   input logic [EXT_W-1:0] c);
    cell_addr = {r[AW-1:0], c[AW-1:0]};
  endfunction

  state_t               st_r, st_nxt;
  phase_t               phase_r, phase_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic [COORD_W-1:0]   start_row_r, start_row_nxt, start_col_r, start_col_nxt;
  logic [COORD_W-1:0]   cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [CFG_W-1:0]     num_rows_r, num_cols_r;
  logic [2:0]           dir_r, dir_nxt;
  logic [1:0]           entry_r, entry_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           ev_r, ev_nxt;
  logic [1:0]           odir_r, odir_nxt;
  logic [COORD_W-1:0]   orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic [COORD_W-1:0]   ofrow_r, ofrow_nxt, ofcol_r, ofcol_nxt;
  logic                 ofin_r, ofin_nxt;

  logic                 mk_we;
  logic [MADDR_W-1:0]   mk_waddr, mk_raddr;
  logic [1:0]           mk_wdata, mk_rdata;
  logic                 sk_we;
  logic [SADDR_W-1:0]   sk_waddr, sk_raddr;
  logic [4:0]           sk_wdata, sk_rdata;

  logic [EXT_W-1:0]     nr, nc, r9, c9, tr, tc, lr9, lc9;
  logic [DEPTH_W-1:0]   depth_m1;
  logic                 in_fire, border, at_start, in_bounds, full, probe_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    if (num_rows_r == '0) begin
      nr = EXT_W'(1);
    end else if ({1'b0, num_rows_r} > EXT_W'(MAX_DIM)) begin
      nr = EXT_W'(MAX_DIM);
    end else begin
      nr = EXT_W'(num_rows_r);
    end
    if (num_cols_r == '0) begin
      nc = EXT_W'(1);
    end else if ({1'b0, num_cols_r} > EXT_W'(MAX_DIM)) begin
      nc = EXT_W'(MAX_DIM);
    end else begin
      nc = EXT_W'(num_cols_r);
    end
  end

  assign r9       = EXT_W'(cur_row_r);
  assign c9       = EXT_W'(cur_col_r);
  assign lr9      = EXT_W'(in_load_row);
  assign lc9      = EXT_W'(in_load_col);
  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign full     = depth_r >= DEPTH_W'(GRID);
  assign border   = (r9 == '0) || (r9 == nr - EXT_W'(1)) ||
                    (c9 == '0) || (c9 == nc - EXT_W'(1));
  assign at_start = (cur_row_r == start_row_r) && (cur_col_r == start_col_r);

  // neighbor of the current cell in direction dir_r
  always_comb begin
    tr        = r9;
    tc        = c9;
    in_bounds = 1'b0;
    case (dir_r[1:0])
      DIR_RIGHT: begin
        tc        = c9 + EXT_W'(1);
        in_bounds = tc < nc;
      end
      DIR_UP: begin
        tr        = r9 - EXT_W'(1);
        in_bounds = r9 != '0;
      end
      DIR_LEFT: begin
        tc        = c9 - EXT_W'(1);
        in_bounds = c9 != '0;
      end
      default: begin
        tr        = r9 + EXT_W'(1);
        in_bounds = tr < nr;
      end
    endcase
  end

  assign probe_ok = in_bounds && (tr < EXT_W'(MAX_DIM)) && (tc < EXT_W'(MAX_DIM)) && !full;

  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    depth_nxt     = depth_r;
    start_row_nxt = start_row_r;
    start_col_nxt = start_col_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    dir_nxt       = dir_r;
    entry_nxt     = entry_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ev_nxt        = ev_r;
    odir_nxt      = odir_r;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    ofrow_nxt     = ofrow_r;
    ofcol_nxt     = ofcol_r;
    ofin_nxt      = ofin_r;
    mk_we         = 1'b0;
    mk_waddr      = cell_addr(lr9, lc9);
    mk_wdata      = MARK_WALL;
    mk_raddr      = cell_addr(tr, tc);
    sk_we         = 1'b0;
    sk_waddr      = depth_m1[SADDR_W-1:0];
    sk_wdata      = {entry_r, dir_r + 3'd1};
    sk_raddr      = depth_m1[SADDR_W-1:0];

    unique case (st_r)
      S_IDLE: begin
        if (in_fire && !in_mode) begin
          if (lr9 < nr && lc9 < nc) begin
            mk_we    = 1'b1;
            mk_wdata = (in_is_start || in_cell_open) ? MARK_OPEN : MARK_WALL;
            if (in_is_start) begin
              start_row_nxt = in_load_row;
              start_col_nxt = in_load_col;
            end
            phase_nxt = PH_IDLE;
            depth_nxt = '0;
          end
        end else if (in_fire) begin
          unique case (phase_r)
            PH_IDLE: begin
              mk_we         = 1'b1;
              mk_waddr      = cell_addr(EXT_W'(start_row_r), EXT_W'(start_col_r));
              mk_wdata      = MARK_SEEN;
              sk_we         = 1'b1;
              sk_waddr      = '0;
              sk_wdata      = '0;
              depth_nxt     = DEPTH_W'(1);
              cur_row_nxt   = start_row_r;
              cur_col_nxt   = start_col_r;
              phase_nxt     = PH_SEARCH;
              out_valid_nxt = 1'b1;
              ev_nxt        = EV_START;
              odir_nxt      = DIR_RIGHT;
              orow_nxt      = start_row_r;
              ocol_nxt      = start_col_r;
              ofrow_nxt     = '0;
              ofcol_nxt     = '0;
              ofin_nxt      = 1'b0;
            end
            PH_SEARCH: begin
              if (depth_r == '0) begin
                phase_nxt     = PH_DONE;
                out_valid_nxt = 1'b1;
                ev_nxt        = EV_NO_EXIT;
                odir_nxt      = DIR_RIGHT;
                orow_nxt      = start_row_r;
                ocol_nxt      = start_col_r;
                ofrow_nxt     = '0;
                ofcol_nxt     = '0;
                ofin_nxt      = 1'b1;
              end else begin
                st_nxt = S_TOP;
              end
            end
            default: ;
          endcase
        end
      end
      S_TOP: begin
        entry_nxt = sk_rdata[4:3];
        if (sk_rdata[2:0] == 3'd0 && border && !at_start) begin
          phase_nxt     = PH_DONE;
          out_valid_nxt = 1'b1;
          ev_nxt        = EV_EXIT;
          odir_nxt      = DIR_RIGHT;
          orow_nxt      = cur_row_r;
          ocol_nxt      = cur_col_r;
          ofrow_nxt     = '0;
          ofcol_nxt     = '0;
          ofin_nxt      = 1'b1;
          st_nxt        = S_IDLE;
        end else begin
          dir_nxt = sk_rdata[2:0];
          st_nxt  = S_PROBE;
        end
      end
      S_PROBE: begin
        if (dir_r[2]) begin
          // every direction tried: return to parent or give up at the root
          out_valid_nxt = 1'b1;
          odir_nxt      = DIR_RIGHT;
          st_nxt        = S_IDLE;
          if (depth_r > DEPTH_W'(1)) begin
            depth_nxt = depth_m1;
            ev_nxt    = EV_BACK;
            ofrow_nxt = cur_row_r;
            ofcol_nxt = cur_col_r;
            ofin_nxt  = 1'b0;
            orow_nxt  = cur_row_r;
            ocol_nxt  = cur_col_r;
            case (entry_r)
              DIR_RIGHT: ocol_nxt = cur_col_r - COORD_W'(1);
              DIR_UP:    orow_nxt = cur_row_r + COORD_W'(1);
              DIR_LEFT:  ocol_nxt = cur_col_r + COORD_W'(1);
              default:   orow_nxt = cur_row_r - COORD_W'(1);
            endcase
            cur_row_nxt = orow_nxt;
            cur_col_nxt = ocol_nxt;
          end else begin
            depth_nxt = '0;
            phase_nxt = PH_DONE;
            ev_nxt    = EV_NO_EXIT;
            orow_nxt  = start_row_r;
            ocol_nxt  = start_col_r;
            ofrow_nxt = '0;
            ofcol_nxt = '0;
            ofin_nxt  = 1'b1;
          end
        end else if (probe_ok) begin
          st_nxt = S_EVAL;
        end else begin
          dir_nxt = dir_r + 3'd1;
        end
      end
      S_EVAL: begin
        if (mk_rdata == MARK_OPEN) begin
          sk_we         = 1'b1;
          mk_we         = 1'b1;
          mk_waddr      = cell_addr(tr, tc);
          mk_wdata      = MARK_SEEN;
          cur_row_nxt   = tr[COORD_W-1:0];
          cur_col_nxt   = tc[COORD_W-1:0];
          out_valid_nxt = 1'b1;
          ev_nxt        = EV_MOVE;
          odir_nxt      = dir_r[1:0];
          orow_nxt      = tr[COORD_W-1:0];
          ocol_nxt      = tc[COORD_W-1:0];
          ofrow_nxt     = '0;
          ofcol_nxt     = '0;
          ofin_nxt      = 1'b0;
          st_nxt        = S_PUSH;
        end else begin
          dir_nxt = dir_r + 3'd1;
          st_nxt  = S_PROBE;
        end
      end
      S_PUSH: begin
        sk_we     = 1'b1;
        sk_waddr  = depth_r[SADDR_W-1:0];
        sk_wdata  = {dir_r[1:0], 3'd0};
        depth_nxt = depth_r + DEPTH_W'(1);
        st_nxt    = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      phase_r     <= PH_IDLE;
      depth_r     <= '0;
      start_row_r <= '0;
      start_col_r <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      num_rows_r  <= CFG_W'(1);
      num_cols_r  <= CFG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      depth_r     <= depth_nxt;
      start_row_r <= start_row_nxt;
      start_col_r <= start_col_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NUM_ROWS) begin
          num_rows_r <= cfg_data;
        end else if (cfg_index == REG_NUM_COLS) begin
          num_cols_r <= cfg_data;
        end
      end
    end
    dir_r   <= dir_nxt;
    entry_r <= entry_nxt;
    ev_r    <= ev_nxt;
    odir_r  <= odir_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    ofrow_r <= ofrow_nxt;
    ofcol_r <= ofcol_nxt;
    ofin_r  <= ofin_nxt;
  end

  gmdfw_ram #(.DW(2), .AW(MADDR_W), .DEPTH(1 << MADDR_W)) u_marks (
    .clk   (clk),
    .we    (mk_we),
    .waddr (mk_waddr),
    .wdata (mk_wdata),
    .raddr (mk_raddr),
    .rdata (mk_rdata)
  );

  gmdfw_ram #(.DW(5), .AW(SADDR_W), .DEPTH(GRID)) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_event_res = ev_r;
  assign out_direction = odir_r;
  assign out_row       = orow_r;
  assign out_col       = ocol_r;
  assign out_from_row  = ofrow_r;
  assign out_from_col  = ofcol_r;
  assign out_finished  = ofin_r;

endmodule

@@ rtl/gmdfw_checker.sv @@
// ----------------------------------------------------------------------------
// Grid maze walker checker
// Port-level properties of the event stream, bound to the walker.
// ----------------------------------------------------------------------------
`include "grid_maze_depth_first_walker_macros.svh"

module gmdfw_checker
  import gmdfw_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_event_res,
  input logic [1:0]         out_direction,
  input logic [COORD_W-1:0] out_from_row,
  input logic               out_finished
);

  `GMDFW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event_res), "event word dropped while stalled")
  `GMDFW_ASSERT_NOW(a_fin_code, out_valid, out_finished == (out_event_res == EV_EXIT || out_event_res == EV_NO_EXIT), "finished flag disagrees with event")
  `GMDFW_ASSERT_NOW(a_dir_zero, out_valid && out_event_res != EV_MOVE, out_direction == DIR_RIGHT, "direction set on non-move word")
  `GMDFW_ASSERT_NOW(a_from_zero, out_valid && out_event_res != EV_BACK, out_from_row == '0, "from row set on non-backtrack word")
  `GMDFW_ASSERT_NOW(a_busy_stall, out_valid && !out_ready, !in_ready, "item taken while event word stalled")

endmodule

bind grid_maze_depth_first_walker gmdfw_checker u_gmdfw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_event_res (out_event_res),
  .out_direction (out_direction),
  .out_from_row  (out_from_row),
  .out_finished  (out_finished)
);
